/* hdl/dhoat_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the double-hashing open-address table.
// No dependencies; used by dhoat_mod_unit, the top level and the testbench files.
package dhoat_pkg;

   localparam int KEY_W     = 31;
   localparam int OP_W      = 2;
   localparam int SIZE_W    = 11;
   localparam int INDEX_W   = 10;
   localparam int SLOT_W    = 2;
   localparam int ENTRY_W   = SLOT_W + KEY_W;
   localparam int DIVD_W    = KEY_W + 1;
   localparam int MOD_STEPS = DIVD_W / 2;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);
   localparam int SIZE_MIN  = 2;
   localparam int SIZE_RST  = 1024;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [SLOT_W-1:0] SLOT_EMPTY    = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_OCCUPIED = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_REMOVED  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD_POS,
      ST_MOD_STEP,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] remainder;
   } mod_rsp_type;

endpackage

/* hdl/dhoat_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dhoat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dhoat_mod_unit.sv */
`timescale 1ns / 1ps
// Iterative remainder unit: key mod divisor, two restoring steps per cycle.
// Depends on dhoat_pkg.
module dhoat_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  dhoat_pkg::mod_cmd_type cmd,
   output dhoat_pkg::mod_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [dhoat_pkg::MOD_CNT_W-1:0]   count_ff, count_in;
   logic [dhoat_pkg::DIVD_W-1:0]      dividend_ff, dividend_in;
   logic [dhoat_pkg::SIZE_W-1:0]      divisor_ff, divisor_in;
   logic [dhoat_pkg::SIZE_W-1:0]      rem_ff, rem_in;
   logic [dhoat_pkg::SIZE_W:0]        part_a;
   logic [dhoat_pkg::SIZE_W:0]        part_b;
   logic [dhoat_pkg::SIZE_W-1:0]      rem_a;
   logic [dhoat_pkg::SIZE_W-1:0]      rem_b;

   always_comb begin
      part_a = {rem_ff, dividend_ff[dhoat_pkg::DIVD_W-1]};
      if (part_a >= {1'b0, divisor_ff}) begin
         part_a = part_a - {1'b0, divisor_ff};
      end
      rem_a  = part_a[dhoat_pkg::SIZE_W-1:0];
      part_b = {rem_a, dividend_ff[dhoat_pkg::DIVD_W-2]};
      if (part_b >= {1'b0, divisor_ff}) begin
         part_b = part_b - {1'b0, divisor_ff};
      end
      rem_b = part_b[dhoat_pkg::SIZE_W-1:0];

      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (cmd.start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = {1'b0, cmd.dividend};
         divisor_in  = cmd.divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[dhoat_pkg::DIVD_W-3:0], 2'b00};
         rem_in      = rem_b;
         count_in    = count_ff + 1'b1;
         if (count_ff == dhoat_pkg::MOD_CNT_W'(dhoat_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* hdl/double_hash_open_address_table_unit.sv */
`timescale 1ns / 1ps
// Top level of the double-hashing open-address table.
// Depends on dhoat_pkg, dhoat_ram and dhoat_mod_unit.
//
// Usage:
//  - req channel carries one word: operation (insert, search, remove) and key.
//    An item is taken when req_valid is high and req_stall is low.
//  - rsp channel returns one word per item: success and slot_index.
//  - csr channel writes table_size (the modulus); write only while idle.
//  - Flow: the item is taken, then two remainders are formed in turn by one
//    shared iterative unit, then each probe passes through a read of the slot
//    RAM and a check; an unused operation code goes straight to the finish
//    state.
//  - One item is in work at a time; req_stall is high until it is done.
//  - Results sit in an output register; a stalled rsp holds the word and
//    the next item is accepted meanwhile, finishing only once rsp frees.
//  - Reset: after reset all TABLE_DEPTH slots of the slot-state RAM are swept
//    to empty, one slot a cycle; req_stall stays high during the sweep.
//    csr writes are taken at any time.
module double_hash_open_address_table_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dhoat_pkg::OP_W-1:0]      req_operation,
   input  logic [dhoat_pkg::KEY_W-1:0]     req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_success,
   output logic [dhoat_pkg::INDEX_W-1:0]   rsp_slot_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dhoat_pkg::SIZE_W-1:0]    csr_table_size
);

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int SIZE_MAX  = (1 << dhoat_pkg::SIZE_W) - 1;
   localparam int SIZE_LIM  = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;

   dhoat_pkg::state_type state_ff, state_in;

   logic [dhoat_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [dhoat_pkg::SIZE_W-1:0]  size_use;
   logic [dhoat_pkg::SIZE_W-1:0]  m_ff, m_in;
   logic [dhoat_pkg::OP_W-1:0]    op_ff, op_in;
   logic [dhoat_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [dhoat_pkg::SIZE_W-1:0]  pos_ff, pos_in;
   logic [dhoat_pkg::SIZE_W-1:0]  step_ff, step_in;
   logic [dhoat_pkg::SIZE_W-1:0]  probe_ff, probe_in;
   logic [dhoat_pkg::SIZE_W:0]    pos_sum;
   logic                          ok_ff, ok_in;
   logic [dhoat_pkg::SIZE_W-1:0]  where_ff, where_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_success_ff, rsp_success_in;
   logic [dhoat_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   dhoat_pkg::mod_cmd_type        mod_cmd;
   dhoat_pkg::mod_rsp_type        mod_rsp;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [dhoat_pkg::ENTRY_W-1:0] wr_data;
   logic [dhoat_pkg::ENTRY_W-1:0] rd_data;
   logic [dhoat_pkg::SLOT_W-1:0]  rd_slot;
   logic [dhoat_pkg::KEY_W-1:0]   rd_key;
   logic                          req_take;
   logic                          rsp_free;

   dhoat_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .rsp   (mod_rsp)
   );

   dhoat_ram #(
      .WIDTH (dhoat_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (AW'(pos_ff)),
      .rd_data (rd_data)
   );

   assign rd_slot   = rd_data[dhoat_pkg::ENTRY_W-1:dhoat_pkg::KEY_W];
   assign rd_key    = rd_data[dhoat_pkg::KEY_W-1:0];
   assign req_stall = (state_ff != dhoat_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      size_in = size_ff;
      if (csr_valid && csr_ready) begin
         size_in = csr_table_size;
      end
      if (size_ff < dhoat_pkg::SIZE_W'(dhoat_pkg::SIZE_MIN)) begin
         size_use = dhoat_pkg::SIZE_W'(dhoat_pkg::SIZE_MIN);
      end else if (size_ff > dhoat_pkg::SIZE_W'(SIZE_LIM)) begin
         size_use = dhoat_pkg::SIZE_W'(SIZE_LIM);
      end else begin
         size_use = size_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      m_in           = m_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      probe_in       = probe_ff;
      ok_in          = ok_ff;
      where_in       = where_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_success_in = rsp_success_ff;
      rsp_index_in   = rsp_index_ff;
      mod_cmd.start    = 1'b0;
      mod_cmd.dividend = key_ff;
      mod_cmd.divisor  = m_ff;
      wr_en          = 1'b0;
      wr_addr        = AW'(pos_ff);
      wr_data        = {dhoat_pkg::SLOT_OCCUPIED, key_ff};
      pos_sum        = {1'b0, pos_ff} + {1'b0, step_ff};
      if (pos_sum >= {1'b0, m_ff}) begin
         pos_sum = pos_sum - {1'b0, m_ff};
      end

      unique case (state_ff)
         dhoat_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = dhoat_pkg::ST_IDLE;
            end
         end
         dhoat_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in    = req_operation;
               key_in   = req_key;
               m_in     = size_use;
               ok_in    = 1'b0;
               where_in = '0;
               if (req_operation == dhoat_pkg::OP_INSERT ||
                   req_operation == dhoat_pkg::OP_SEARCH ||
                   req_operation == dhoat_pkg::OP_REMOVE) begin
                  mod_cmd.start    = 1'b1;
                  mod_cmd.dividend = req_key;
                  mod_cmd.divisor  = size_use;
                  state_in         = dhoat_pkg::ST_MOD_POS;
               end else begin
                  state_in = dhoat_pkg::ST_FINISH;
               end
            end
         end
         dhoat_pkg::ST_MOD_POS: begin
            if (mod_rsp.done) begin
               pos_in          = mod_rsp.remainder;
               mod_cmd.start   = 1'b1;
               mod_cmd.divisor = m_ff - 1'b1;
               state_in        = dhoat_pkg::ST_MOD_STEP;
            end
         end
         dhoat_pkg::ST_MOD_STEP: begin
            if (mod_rsp.done) begin
               step_in  = mod_rsp.remainder + 1'b1;
               probe_in = '0;
               state_in = dhoat_pkg::ST_READ;
            end
         end
         dhoat_pkg::ST_READ: begin
            state_in = dhoat_pkg::ST_CHECK;
         end
         dhoat_pkg::ST_CHECK: begin
            if (op_ff == dhoat_pkg::OP_INSERT && rd_slot != dhoat_pkg::SLOT_OCCUPIED) begin
               wr_en    = 1'b1;
               ok_in    = 1'b1;
               where_in = pos_ff;
               state_in = dhoat_pkg::ST_FINISH;
            end else if (op_ff != dhoat_pkg::OP_INSERT &&
                         rd_slot == dhoat_pkg::SLOT_OCCUPIED && rd_key == key_ff) begin
               ok_in    = 1'b1;
               where_in = pos_ff;
               if (op_ff == dhoat_pkg::OP_REMOVE) begin
                  wr_en    = 1'b1;
                  wr_data  = {dhoat_pkg::SLOT_REMOVED, key_ff};
                  where_in = '0;
               end
               state_in = dhoat_pkg::ST_FINISH;
            end else if (op_ff != dhoat_pkg::OP_INSERT && rd_slot == dhoat_pkg::SLOT_EMPTY) begin
               state_in = dhoat_pkg::ST_FINISH;
            end else if (probe_ff == m_ff - 1'b1) begin
               state_in = dhoat_pkg::ST_FINISH;
            end else begin
               pos_in   = pos_sum[dhoat_pkg::SIZE_W-1:0];
               probe_in = probe_ff + 1'b1;
               state_in = dhoat_pkg::ST_READ;
            end
         end
         dhoat_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = ok_ff;
               rsp_index_in   = ok_ff ? where_ff[dhoat_pkg::INDEX_W-1:0] : '0;
               state_in       = dhoat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dhoat_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhoat_pkg::ST_CLEAR;
         size_ff      <= dhoat_pkg::SIZE_W'(dhoat_pkg::SIZE_RST);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff           <= m_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      pos_ff         <= pos_in;
      step_ff        <= step_in;
      probe_ff       <= probe_in;
      ok_ff          <= ok_in;
      where_ff       <= where_in;
      rsp_success_ff <= rsp_success_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_slot_index = rsp_index_ff;

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != dhoat_pkg::ST_IDLE))
      else $error("accepted word did not start work");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dhoat_pkg::ST_CLEAR) |-> req_stall)
      else $error("request taken during clearing sweep");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dhoat_pkg::ST_CHECK) |-> (probe_ff < m_ff && pos_ff < m_ff))
      else $error("probe position or count out of range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == dhoat_pkg::ST_FINISH))
      else $error("result word raised outside finish");

   a_rsp_held_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && state_ff == dhoat_pkg::ST_FINISH) |=>
      (state_ff == dhoat_pkg::ST_FINISH))
      else $error("finished word overran a stalled result");

endmodule

/* tb/sv/double_hash_open_address_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the double-hashing open-address table: watches the req, rsp and csr channels,
// predicts each result from its own copy of the slot store and table size, and compares.
// Depends on dhoat_pkg; instantiated beside the block by double_hash_open_address_table_unit_tb.
module double_hash_open_address_table_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [dhoat_pkg::OP_W-1:0]    req_operation,
   input  logic [dhoat_pkg::KEY_W-1:0]   req_key,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_success,
   input  logic [dhoat_pkg::INDEX_W-1:0] rsp_slot_index,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [dhoat_pkg::SIZE_W-1:0]  csr_table_size,
   output int                            fail_count,
   output int                            pending_count
);

   localparam int DEPTH = 1024;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic                          success;
      logic [dhoat_pkg::INDEX_W-1:0] slot_index;
   } answer_type;

   logic [dhoat_pkg::SLOT_W-1:0] slot_mark [DEPTH];
   logic [dhoat_pkg::KEY_W-1:0]  slot_held [DEPTH];
   logic [dhoat_pkg::SIZE_W-1:0] size_reg = dhoat_pkg::SIZE_W'(dhoat_pkg::SIZE_RST);
   answer_type                   expected_answers [$];
   answer_type                   want;
   int                           errors = 0;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   function automatic answer_type probe_table(logic [dhoat_pkg::OP_W-1:0] op,
                                              logic [dhoat_pkg::KEY_W-1:0] key);
      int unsigned m;
      int unsigned pos;
      int unsigned stride;
      logic        hit;
      answer_type  ans;
      m = size_reg;
      if (m < dhoat_pkg::SIZE_MIN) m = dhoat_pkg::SIZE_MIN;
      if (m > DEPTH) m = DEPTH;
      pos = key % m;
      stride = 1 + key % (m - 1);
      hit = 1'b0;
      ans = '0;
      case (op)
         dhoat_pkg::OP_INSERT: begin
            for (int unsigned n = 0; n < m; n++) begin
               if (slot_mark[pos] != dhoat_pkg::SLOT_OCCUPIED) begin
                  slot_mark[pos] = dhoat_pkg::SLOT_OCCUPIED;
                  slot_held[pos] = key;
                  ans.success = 1'b1;
                  ans.slot_index = dhoat_pkg::INDEX_W'(pos);
                  break;
               end
               pos += stride;
               if (pos >= m) pos -= m;
            end
         end
         dhoat_pkg::OP_SEARCH, dhoat_pkg::OP_REMOVE: begin
            for (int unsigned n = 0; n < m; n++) begin
               if (slot_mark[pos] == dhoat_pkg::SLOT_OCCUPIED && slot_held[pos] == key) begin
                  hit = 1'b1;
                  break;
               end
               if (slot_mark[pos] == dhoat_pkg::SLOT_EMPTY) break;
               pos += stride;
               if (pos >= m) pos -= m;
            end
            if (hit) begin
               ans.success = 1'b1;
               ans.slot_index = dhoat_pkg::INDEX_W'(pos);
               if (op == dhoat_pkg::OP_REMOVE) begin
                  slot_mark[pos] = dhoat_pkg::SLOT_REMOVED;
                  ans.slot_index = '0;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) slot_mark[i] = dhoat_pkg::SLOT_EMPTY;
         size_reg = dhoat_pkg::SIZE_W'(dhoat_pkg::SIZE_RST);
         expected_answers.delete();
      end else begin
         if (csr_valid && csr_ready) size_reg = csr_table_size;
         if (req_valid && !req_stall)
            expected_answers.push_back(probe_table(req_operation, req_key));
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: unexpected word: success %0d slot_index %0d",
                           $realtime, rsp_success, rsp_slot_index);
            end else begin
               want = expected_answers.pop_front();
               if (want.success !== rsp_success || want.slot_index !== rsp_slot_index) begin
                  errors++;
                  if (errors <= REPORT_MAX)
                     $display({"%0t: mismatch: expected success %0d slot_index %0d, ",
                               "got success %0d slot_index %0d"},
                              $realtime, want.success, want.slot_index,
                              rsp_success, rsp_slot_index);
               end
            end
         end
      end
      pending_count <= expected_answers.size();
      fail_count <= errors;
   end

endmodule

/* tb/sv/double_hash_open_address_table_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for double_hash_open_address_table_unit: drives directed and random
// insert, search and remove words over several table sizes and gives the verdict.
// Depends on dhoat_pkg, the block and double_hash_open_address_table_checker.
module double_hash_open_address_table_unit_tb;

   localparam logic [dhoat_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [dhoat_pkg::KEY_W-1:0] KEY_MAX = 31'h7FFFFFFF;
   localparam int DEPTH = 1024;
   localparam int LIMIT = 3000000;
   localparam int LONG_HOLD = 600;
   localparam int PHASE_ITEMS = 32;
   localparam int POOL_MAX = 32;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [dhoat_pkg::OP_W-1:0]    req_operation = dhoat_pkg::OP_INSERT;
   logic [dhoat_pkg::KEY_W-1:0]   req_key = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b1;
   logic                          rsp_success;
   logic [dhoat_pkg::INDEX_W-1:0] rsp_slot_index;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [dhoat_pkg::SIZE_W-1:0]  csr_table_size = '0;

   int                            fail_count;
   int                            pending_count;
   int                            cycles = 0;
   bit                            idle_on = 1'b1;
   bit                            hold_rsp = 1'b0;
   int unsigned                   size_now = DEPTH;
   logic [dhoat_pkg::KEY_W-1:0]   live_keys [$];

   double_hash_open_address_table_unit #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_success   (rsp_success),
      .rsp_slot_index(rsp_slot_index),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_table_size(csr_table_size)
   );

   double_hash_open_address_table_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_success   (rsp_success),
      .rsp_slot_index(rsp_slot_index),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_table_size(csr_table_size),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // stall the result side per word; hold off long on request
   initial begin : result_side
      int wait_cycles;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         wait_cycles = idle_on ? $urandom_range(0, 16) : 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_word(logic [dhoat_pkg::OP_W-1:0] op, logic [dhoat_pkg::KEY_W-1:0] key);
      int gap;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key <= key;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (op == dhoat_pkg::OP_INSERT) begin
         live_keys.push_back(key);
         if (live_keys.size() > POOL_MAX) void'(live_keys.pop_front());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_size(logic [dhoat_pkg::SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_table_size <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      size_now = value < dhoat_pkg::SIZE_MIN ? dhoat_pkg::SIZE_MIN :
                 (value > DEPTH ? DEPTH : value);
   endtask

   function automatic logic [dhoat_pkg::KEY_W-1:0] pick_key();
      int unsigned r;
      logic [dhoat_pkg::KEY_W-1:0] base;
      r = $urandom_range(0, 9);
      base = live_keys.size() > 0 ? live_keys[$urandom_range(0, live_keys.size() - 1)]
                                  : dhoat_pkg::KEY_W'($urandom_range(0, 63));
      case (r)
         0, 1: return dhoat_pkg::KEY_W'($urandom());
         2, 3: return dhoat_pkg::KEY_W'($urandom_range(0, 63));
         4, 5, 6: return base;
         7, 8: return dhoat_pkg::KEY_W'(base + size_now * $urandom_range(1, 8));
         default: return $urandom_range(0, 1) ? KEY_MAX : '0;
      endcase
   endfunction

   function automatic logic [dhoat_pkg::OP_W-1:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 8) return dhoat_pkg::OP_INSERT;
      if (r < 14) return dhoat_pkg::OP_SEARCH;
      if (r < 19) return dhoat_pkg::OP_REMOVE;
      return OP_UNUSED;
   endfunction

   initial begin : stimulus
      logic [dhoat_pkg::SIZE_W-1:0] sizes [12];
      sizes = '{11'd2, 11'd0, 11'd7, 11'd13, 11'd1024, 11'd1,
                11'd3, 11'd2047, 11'd16, 11'd31, 11'd1500, 11'd5};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset table size
      send_word(dhoat_pkg::OP_SEARCH, 31'd5);
      send_word(dhoat_pkg::OP_INSERT, 31'd0);
      send_word(dhoat_pkg::OP_INSERT, KEY_MAX);
      send_word(dhoat_pkg::OP_INSERT, 31'd1024);
      send_word(dhoat_pkg::OP_SEARCH, 31'd1024);
      send_word(dhoat_pkg::OP_SEARCH, KEY_MAX);
      send_word(dhoat_pkg::OP_INSERT, 31'd1024);
      send_word(dhoat_pkg::OP_REMOVE, 31'd1024);
      send_word(dhoat_pkg::OP_SEARCH, 31'd1024);
      send_word(dhoat_pkg::OP_REMOVE, 31'd1024);
      send_word(dhoat_pkg::OP_SEARCH, 31'd1024);
      send_word(dhoat_pkg::OP_INSERT, 31'd2048);
      send_word(OP_UNUSED, KEY_MAX);
      send_word(OP_UNUSED, 31'd0);
      send_word(dhoat_pkg::OP_REMOVE, 31'd12345);
      send_word(dhoat_pkg::OP_SEARCH, 31'd0);
      send_word(dhoat_pkg::OP_REMOVE, 31'd0);
      send_word(dhoat_pkg::OP_INSERT, 31'd0);
      send_word(dhoat_pkg::OP_SEARCH, 31'd2048);
      send_word(dhoat_pkg::OP_REMOVE, KEY_MAX);

      foreach (sizes[p]) begin
         drain();
         write_size(sizes[p]);
         idle_on = $urandom_range(0, 3) != 0;
         if (p == 3) begin
            idle_on = 1'b0;
            hold_rsp = 1'b1;
         end
         repeat (PHASE_ITEMS) send_word(pick_op(), pick_key());
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
